// ===== design/assert_macros.svh =====
// Assertion helpers used by matrix3x3_inverse.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MI3_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define MI3_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mi3_pkg.sv =====
package mi3_pkg;

    localparam int NUM_ELEM = 9;

    typedef logic [3:0] idx_t;

    // Cofactor k = a[PLUS_A[k]] * a[PLUS_B[k]] - a[MINUS_A[k]] * a[MINUS_B[k]]
    localparam idx_t PLUS_A  [NUM_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam idx_t PLUS_B  [NUM_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam idx_t MINUS_A [NUM_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam idx_t MINUS_B [NUM_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    // Determinant expands along row 0: cofactors that pair with a00, a01, a02
    localparam idx_t DET_COF [3] = '{0, 3, 6};

endpackage

// ===== design/mi3_adj.sv =====
module mi3_adj #(
    parameter int ELEM_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [ELEM_WIDTH-1:0]  a       [mi3_pkg::NUM_ELEM],
    output logic signed [2*ELEM_WIDTH:0]  adj     [mi3_pkg::NUM_ELEM],
    output logic signed [ELEM_WIDTH-1:0]  row0    [3]
);

    localparam int W  = ELEM_WIDTH;
    localparam int AW = 2 * W + 1;

    logic signed [2*W-1:0] pp_reg    [mi3_pkg::NUM_ELEM];
    logic signed [2*W-1:0] pm_reg    [mi3_pkg::NUM_ELEM];
    logic signed [AW-1:0]  adj_reg   [mi3_pkg::NUM_ELEM];
    logic signed [W-1:0]   row_a_reg [3];
    logic signed [W-1:0]   row_b_reg [3];

    // Stage 1: element pair products; stage 2: cofactor differences
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < mi3_pkg::NUM_ELEM; i++) begin
                pp_reg[i]  <= a[mi3_pkg::PLUS_A[i]] * a[mi3_pkg::PLUS_B[i]];
                pm_reg[i]  <= a[mi3_pkg::MINUS_A[i]] * a[mi3_pkg::MINUS_B[i]];
                adj_reg[i] <= AW'(pp_reg[i]) - AW'(pm_reg[i]);
            end
            for (int k = 0; k < 3; k++) begin
                row_a_reg[k] <= a[k];
                row_b_reg[k] <= row_a_reg[k];
            end
        end
    end

    assign adj  = adj_reg;
    assign row0 = row_b_reg;

endmodule

// ===== design/mi3_det.sv =====
module mi3_det #(
    parameter int ELEM_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [2*ELEM_WIDTH:0]  adj      [mi3_pkg::NUM_ELEM],
    input  logic signed [ELEM_WIDTH-1:0]  row0     [3],
    output logic signed [2*ELEM_WIDTH:0]  adj_out  [mi3_pkg::NUM_ELEM],
    output logic        [3*ELEM_WIDTH-1:0] det_mag,
    output logic                          det_neg,
    output logic                          det_zero
);

    localparam int W  = ELEM_WIDTH;
    localparam int AW = 2 * W + 1;
    localparam int PW = 2 * W + 1;
    localparam int DW = 3 * W + 1;
    localparam int SW = DW + 2;

    logic signed [PW-1:0] pl_reg [3];
    logic signed [PW-1:0] ph_reg [3];
    logic signed [AW-1:0] adj_a_reg [mi3_pkg::NUM_ELEM];
    logic signed [AW-1:0] adj_b_reg [mi3_pkg::NUM_ELEM];
    logic signed [AW-1:0] adj_c_reg [mi3_pkg::NUM_ELEM];
    logic signed [DW-1:0] det_reg;
    logic signed [DW-1:0] det_next;
    logic signed [SW-1:0] acc;
    logic signed [DW-1:0] det_abs;
    logic [3*W-1:0]       mag_reg;
    logic                 neg_reg;
    logic                 zero_reg;

    // Sum of the split partial products, shifted back into place
    always_comb begin
        acc = '0;
        for (int k = 0; k < 3; k++) begin
            acc = acc + (SW'(ph_reg[k]) <<< W) + SW'(pl_reg[k]);
        end
        det_next = $signed(acc[DW-1:0]);
    end

    assign det_abs = det_reg[DW-1] ? -det_reg : det_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                pl_reg[k] <= row0[k]
                    * $signed({1'b0, adj[mi3_pkg::DET_COF[k]][W-1:0]});
                ph_reg[k] <= row0[k] * $signed(adj[mi3_pkg::DET_COF[k]][2*W:W]);
            end
            det_reg  <= det_next;
            mag_reg  <= det_abs[3*W-1:0];
            neg_reg  <= det_reg[DW-1];
            zero_reg <= (det_reg == '0);
            for (int i = 0; i < mi3_pkg::NUM_ELEM; i++) begin
                adj_a_reg[i] <= adj[i];
                adj_b_reg[i] <= adj_a_reg[i];
                adj_c_reg[i] <= adj_b_reg[i];
            end
        end
    end

    assign adj_out  = adj_c_reg;
    assign det_mag  = mag_reg;
    assign det_neg  = neg_reg;
    assign det_zero = zero_reg;

endmodule

// ===== design/mi3_div.sv =====
module mi3_div #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           aclk,
    input  logic                           en,
    input  logic signed [2*ELEM_WIDTH:0]   adj,
    input  logic        [3*ELEM_WIDTH-1:0] det_mag,
    input  logic                           det_neg,
    input  logic        [3*ELEM_WIDTH-1:0] den     [ELEM_WIDTH+1],
    output logic signed [ELEM_WIDTH-1:0]   quot
);

    localparam int W    = ELEM_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int AW   = 2 * W + 1;
    localparam int MW   = 2 * W;
    localparam int NW   = MW + 2 * F;
    localparam int NB   = W + 1;
    localparam int HW   = NW - NB;
    localparam int RW   = 3 * W + 1;
    localparam int EXTW = (HW > RW) ? HW : RW;

    localparam logic [NB-1:0] MAXP = {2'b00, {(W - 1){1'b1}}};
    localparam logic [NB-1:0] MINM = {2'b01, {(W - 1){1'b0}}};

    logic                 adj_neg;
    logic signed [AW-1:0] adj_abs;
    logic [NW-1:0]        num;
    logic [EXTW-1:0]      hi_ext;
    logic [EXTW-1:0]      den_ext;

    logic [RW-1:0] r_reg   [NB+1];
    logic [NB-1:0] lo_reg  [NB+1];
    logic [NB-1:0] q_reg   [NB+1];
    logic          neg_reg [NB+1];
    logic          ovf_reg [NB+1];

    logic [NB-1:0] m_sat;
    logic [NB-1:0] m_neg;

    // Numerator |adj| * 2^(2F); bits above the quotient range seed the remainder
    assign adj_neg = adj[AW-1];
    assign adj_abs = adj_neg ? -adj : adj;
    assign num     = {adj_abs[MW-1:0], {(2 * F){1'b0}}};
    assign hi_ext  = EXTW'(num[NW-1:NB]);
    assign den_ext = EXTW'(det_mag);

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= hi_ext[RW-1:0];
            lo_reg[0]  <= num[NB-1:0];
            q_reg[0]   <= '0;
            neg_reg[0] <= adj_neg ^ det_neg;
            ovf_reg[0] <= (hi_ext >= den_ext);
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar j = 1; j <= NB; j++) begin : g_bit
        logic [RW-1:0] t;
        logic [RW-1:0] d;
        logic          ge;

        assign d  = RW'(den[j-1]);
        assign t  = {r_reg[j-1][RW-2:0], lo_reg[j-1][NB-j]};
        assign ge = (t >= d);

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[j]   <= ge ? (t - d) : t;
                q_reg[j]   <= q_reg[j-1] | (NB'(ge) << (NB - j));
                lo_reg[j]  <= lo_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    // Saturate to the signed element range
    always_comb begin
        if (neg_reg[NB]) begin
            m_sat = (ovf_reg[NB] || (q_reg[NB] > MINM)) ? MINM : q_reg[NB];
        end else begin
            m_sat = (ovf_reg[NB] || (q_reg[NB] > MAXP)) ? MAXP : q_reg[NB];
        end
        m_neg = (~m_sat) + NB'(1);
    end

    assign quot = neg_reg[NB] ? $signed(m_neg[W-1:0]) : $signed(m_sat[W-1:0]);

endmodule

// ===== design/matrix3x3_inverse.sv =====
// Channel  Direction  Handshake            Payload
// s_       in         s_valid / s_ready    s_a00 .. s_a22, signed Q16.16 row-major
// m_       out        m_valid / m_ready    m_inv00 .. m_inv22, m_singular
//
// One matrix per cycle while the output register is empty or taken.
// The bit-serial divider lanes, one quotient bit per stage, set the depth.
// aresetn (synchronous, active low) clears the valid bits only.
// All stages advance together while the output register is empty or taken;
// a stall from m_ready holds every stage, bubbles included.
module matrix3x3_inverse #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [ELEM_WIDTH-1:0]  s_a00,
    input  logic signed [ELEM_WIDTH-1:0]  s_a01,
    input  logic signed [ELEM_WIDTH-1:0]  s_a02,
    input  logic signed [ELEM_WIDTH-1:0]  s_a10,
    input  logic signed [ELEM_WIDTH-1:0]  s_a11,
    input  logic signed [ELEM_WIDTH-1:0]  s_a12,
    input  logic signed [ELEM_WIDTH-1:0]  s_a20,
    input  logic signed [ELEM_WIDTH-1:0]  s_a21,
    input  logic signed [ELEM_WIDTH-1:0]  s_a22,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [ELEM_WIDTH-1:0]  m_inv00,
    output logic signed [ELEM_WIDTH-1:0]  m_inv01,
    output logic signed [ELEM_WIDTH-1:0]  m_inv02,
    output logic signed [ELEM_WIDTH-1:0]  m_inv10,
    output logic signed [ELEM_WIDTH-1:0]  m_inv11,
    output logic signed [ELEM_WIDTH-1:0]  m_inv12,
    output logic signed [ELEM_WIDTH-1:0]  m_inv20,
    output logic signed [ELEM_WIDTH-1:0]  m_inv21,
    output logic signed [ELEM_WIDTH-1:0]  m_inv22,
    output logic                          m_singular
);

`include "assert_macros.svh"

    localparam int W   = ELEM_WIDTH;
    // products, cofactors, det partials, det sum, det magnitude,
    // divider seed, W+1 quotient bits, output register
    localparam int LAT = W + 8;
    // pipeline stage at which the divider seed and first divisor copy sit
    localparam int SEED_STAGE = 5;

    logic                  en;
    logic [LAT-1:0]        vld_reg;
    logic signed [W-1:0]   a        [mi3_pkg::NUM_ELEM];
    logic signed [2*W:0]   adj      [mi3_pkg::NUM_ELEM];
    logic signed [W-1:0]   row0     [3];
    logic signed [2*W:0]   adj_d    [mi3_pkg::NUM_ELEM];
    logic [3*W-1:0]        det_mag;
    logic                  det_neg;
    logic                  det_zero;
    logic [3*W-1:0]        den_reg  [W+1];
    logic                  sing_reg [W+2];
    logic signed [W-1:0]   quot     [mi3_pkg::NUM_ELEM];
    logic signed [W-1:0]   inv_reg  [mi3_pkg::NUM_ELEM];
    logic                  sing_out_reg;

    // Advance the whole pipe whenever the output register can take a transfer
    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    assign a[0] = s_a00;
    assign a[1] = s_a01;
    assign a[2] = s_a02;
    assign a[3] = s_a10;
    assign a[4] = s_a11;
    assign a[5] = s_a12;
    assign a[6] = s_a20;
    assign a[7] = s_a21;
    assign a[8] = s_a22;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    mi3_adj #(
        .ELEM_WIDTH (W)
    ) u_adj (
        .aclk (aclk),
        .en   (en),
        .a    (a),
        .adj  (adj),
        .row0 (row0)
    );

    mi3_det #(
        .ELEM_WIDTH (W)
    ) u_det (
        .aclk     (aclk),
        .en       (en),
        .adj      (adj),
        .row0     (row0),
        .adj_out  (adj_d),
        .det_mag  (det_mag),
        .det_neg  (det_neg),
        .det_zero (det_zero)
    );

    // Carry the divisor and the singular flag alongside the divider stages
    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0]  <= det_mag;
            sing_reg[0] <= det_zero;
            for (int j = 1; j <= W; j++) begin
                den_reg[j] <= den_reg[j-1];
            end
            for (int j = 1; j <= W + 1; j++) begin
                sing_reg[j] <= sing_reg[j-1];
            end
        end
    end

    for (genvar i = 0; i < mi3_pkg::NUM_ELEM; i++) begin : g_lane
        mi3_div #(
            .ELEM_WIDTH (W),
            .FRAC_BITS  (FRAC_BITS)
        ) u_div (
            .aclk    (aclk),
            .en      (en),
            .adj     (adj_d[i]),
            .det_mag (det_mag),
            .det_neg (det_neg),
            .den     (den_reg),
            .quot    (quot[i])
        );
    end

    // Output register: drop the quotients of a singular matrix
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < mi3_pkg::NUM_ELEM; i++) begin
                inv_reg[i] <= sing_reg[W+1] ? '0 : quot[i];
            end
            sing_out_reg <= sing_reg[W+1];
        end
    end

    assign m_inv00    = inv_reg[0];
    assign m_inv01    = inv_reg[1];
    assign m_inv02    = inv_reg[2];
    assign m_inv10    = inv_reg[3];
    assign m_inv11    = inv_reg[4];
    assign m_inv12    = inv_reg[5];
    assign m_inv20    = inv_reg[6];
    assign m_inv21    = inv_reg[7];
    assign m_inv22    = inv_reg[8];
    assign m_singular = sing_out_reg;

    `MI3_ASSERT(a_sing_zero, m_valid && m_singular |-> m_inv00 == '0 && m_inv11 == '0 && m_inv22 == '0 && m_inv01 == '0 && m_inv12 == '0, "singular result carries nonzero elements")
    `MI3_ASSERT(a_stall_src, !s_ready |-> m_valid && !m_ready, "input stalled without an output stall")
    `MI3_ASSERT(a_sing_den, vld_reg[SEED_STAGE] |-> sing_reg[0] == (den_reg[0] == '0), "singular flag disagrees with divisor")
    `MI3_ASSERT_NEXT(a_out_load, en && vld_reg[LAT-2], m_valid, "finished item did not reach the output register")

endmodule

// ===== bench/inverse_checker.sv =====
module inverse_checker (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [8:0][31:0] s_elem,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [8:0][31:0] m_elem,
    input  logic             m_singular,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] wide_t;
    typedef struct packed {
        logic [8:0][31:0] elem;
        logic             singular;
    } inverse_t;

    inverse_t expected_inverses[$];

    function automatic wide_t widen(logic [31:0] v);
        return wide_t'($signed(v));
    endfunction

    // Adjugate over determinant at full width; Q16.16 quotient, truncated, saturated.
    function automatic inverse_t predict_inverse(logic [8:0][31:0] a);
        wide_t    e[9];
        wide_t    cof[9];
        wide_t    det;
        wide_t    quot;
        inverse_t r;
        for (int i = 0; i < 9; i++) e[i] = widen(a[i]);
        cof[0] = e[4] * e[8] - e[5] * e[7];
        cof[1] = e[2] * e[7] - e[1] * e[8];
        cof[2] = e[1] * e[5] - e[2] * e[4];
        cof[3] = e[5] * e[6] - e[3] * e[8];
        cof[4] = e[0] * e[8] - e[2] * e[6];
        cof[5] = e[2] * e[3] - e[0] * e[5];
        cof[6] = e[3] * e[7] - e[4] * e[6];
        cof[7] = e[1] * e[6] - e[0] * e[7];
        cof[8] = e[0] * e[4] - e[1] * e[3];
        det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
        r = '0;
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        for (int i = 0; i < 9; i++) begin
            quot = (cof[i] <<< 32) / det;
            if (quot > wide_t'(32'sh7fffffff))
                r.elem[i] = 32'h7fffffff;
            else if (quot < -wide_t'(64'sh80000000))
                r.elem[i] = 32'h80000000;
            else
                r.elem[i] = quot[31:0];
        end
        return r;
    endfunction

    initial fail_count = 0;
    initial pending = 0;

    always @(posedge aclk) begin
        inverse_t want;
        inverse_t got;
        if (aresetn) begin
            if (s_valid && s_ready) expected_inverses.push_back(predict_inverse(s_elem));
            if (m_valid && m_ready) begin
                got.elem = m_elem;
                got.singular = m_singular;
                if (expected_inverses.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result transfer %h", got);
                end else begin
                    want = expected_inverses.pop_front();
                    if (want != got) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            for (int i = 0; i < 9; i++)
                                if (want.elem[i] != got.elem[i])
                                    $display("inv%0d%0d: expected %h, got %h",
                                             i / 3, i % 3, want.elem[i], got.elem[i]);
                            if (want.singular != got.singular)
                                $display("singular: expected %b, got %b",
                                         want.singular, got.singular);
                        end
                    end
                end
            end
        end
        pending = expected_inverses.size();
    end
endmodule

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] ONE = 32'h0001_0000;   // 1.0 in Q16.16

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [8:0][31:0] s_elem;
    logic             m_valid;
    logic             m_ready;
    logic [8:0][31:0] m_elem;
    logic             m_singular;
    int               fail_count;
    int               pending;
    int               cycle_count;
    logic             sender_steady;   // disables sender idling for a stretch

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    matrix3x3_inverse dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_a00      (s_elem[0]),
        .s_a01      (s_elem[1]),
        .s_a02      (s_elem[2]),
        .s_a10      (s_elem[3]),
        .s_a11      (s_elem[4]),
        .s_a12      (s_elem[5]),
        .s_a20      (s_elem[6]),
        .s_a21      (s_elem[7]),
        .s_a22      (s_elem[8]),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_inv00    (m_elem[0]),
        .m_inv01    (m_elem[1]),
        .m_inv02    (m_elem[2]),
        .m_inv10    (m_elem[3]),
        .m_inv11    (m_elem[4]),
        .m_inv12    (m_elem[5]),
        .m_inv20    (m_elem[6]),
        .m_inv21    (m_elem[7]),
        .m_inv22    (m_elem[8]),
        .m_singular (m_singular)
    );

    inverse_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_elem     (s_elem),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_elem     (m_elem),
        .m_singular (m_singular),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one matrix: idle a random number of cycles first (lowering valid only
    // when a gap is taken), then hold the payload until the transfer happens.
    task automatic send_matrix(input logic [8:0][31:0] m);
        int gap;
        gap = 0;
        if (!sender_steady)
            while ($urandom_range(0, 99) < 33) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_elem  <= m;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Element in a moderate range, +/-8.0 with random fraction.
    function automatic logic [31:0] modest_elem();
        return 32'($signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
    endfunction

    function automatic logic [8:0][31:0] random_matrix();
        logic [8:0][31:0] m;
        int               kind;
        int               r;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) m[i] = modest_elem();
        case (kind)
            0, 1: begin
                // full-range raw bits
                for (int i = 0; i < 9; i++) m[i] = $urandom();
            end
            2: begin
                // copy one row onto another: determinant exactly zero
                r = $urandom_range(0, 2);
                for (int c = 0; c < 3; c++) m[((r + 1) % 3) * 3 + c] = m[r * 3 + c];
            end
            3: begin
                // a zero column: singular
                r = $urandom_range(0, 2);
                for (int k = 0; k < 3; k++) m[k * 3 + r] = '0;
            end
            4: begin
                // tiny entries: inverse saturates
                for (int i = 0; i < 9; i++) m[i] = 32'($signed($urandom_range(0, 15)) - 8);
            end
            5: begin
                // near-diagonal, well conditioned
                for (int i = 0; i < 9; i++) m[i] = 32'($signed(m[i]) >>> 4);
                m[0] = m[0] + ONE;
                m[4] = m[4] - ONE;
                m[8] = m[8] + (ONE << 1);
            end
            default: begin
            end
        endcase
        return m;
    endfunction

    // Receiver: random stalls, one long hold-off so the pipe fills and pushes
    // back on the sender, and long stretches always ready, one of them while
    // the sender never idles.
    initial begin
        m_ready = 1'b0;
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= 300 && cycle_count < 500)
                m_ready <= 1'b0;
            else if ((cycle_count >= 900 && cycle_count < 1300) || sender_steady)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(0, 99) >= 33);
        end
    end

    initial begin
        #2ms;
        $display("matrix3x3_inverse regression: fail");
        $finish;
    end

    initial begin
        logic [8:0][31:0] m;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_elem  = '0;
        sender_steady = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // identity
        m = '0;
        m[0] = ONE; m[4] = ONE; m[8] = ONE;
        send_matrix(m);
        // diagonal with mixed signs and scales
        m = '0;
        m[0] = -(ONE * 2); m[4] = -(ONE * 4); m[8] = ONE >> 1;
        send_matrix(m);
        // zero matrix: singular
        send_matrix('0);
        // every element at maximum: rank one, singular
        for (int i = 0; i < 9; i++) m[i] = 32'h7fffffff;
        send_matrix(m);
        // every element at minimum
        for (int i = 0; i < 9; i++) m[i] = 32'h80000000;
        send_matrix(m);
        // diagonal extremes: inverse far out of range on both signs
        m = '0;
        m[0] = 32'h80000000; m[4] = 32'h7fffffff; m[8] = 32'hffffffff;
        send_matrix(m);
        m = '0;
        m[0] = 32'h00000001; m[4] = 32'hffffffff; m[8] = 32'h00000001;
        send_matrix(m);
        // all bits set (-1 LSB) with anti-diagonal extremes
        for (int i = 0; i < 9; i++) m[i] = 32'hffffffff;
        m[2] = 32'h7fffffff; m[6] = 32'h80000000;
        send_matrix(m);
        // signed permutation matrix
        m = '0;
        m[1] = ONE; m[5] = ONE; m[6] = -ONE;
        send_matrix(m);
        // alternating bit patterns
        for (int i = 0; i < 9; i++) m[i] = (i % 2) ? 32'h55555555 : 32'haaaaaaaa;
        m[4] = 32'h12345678;
        send_matrix(m);
        // large diagonal: small inverse, near truncation to zero
        m = '0;
        m[0] = 32'h7fff0000; m[4] = 32'h80000000; m[8] = 32'h40000000;
        send_matrix(m);

        // Random part, with a stretch where the sender never idles.
        for (int n = 0; n < 750; n++) begin
            sender_steady = (n >= 250 && n < 400);
            send_matrix(random_matrix());
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (fail_count == 0)
            $display("matrix3x3_inverse regression: pass");
        else
            $display("matrix3x3_inverse regression: fail");
        $finish;
    end
endmodule
